@@ hdl/dia_pkg.sv @@
// ----------------------------------------------------------------------------
// dia_pkg
// Shared types and constants of the descriptor id allocator: pool geometry,
// action and status codes, controller states, command/status structs and the
// lowest-set-bit encoder used by the bitmap scan.
// ----------------------------------------------------------------------------
package dia_pkg;

  // pool geometry
  localparam int unsigned MAX_IDS   = 256;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned NUM_WORDS = MAX_IDS / WORD_BITS;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned WIDX_W    = $clog2(NUM_WORDS);
  localparam int unsigned HINT_W    = $clog2(MAX_IDS) + 1;
  localparam int unsigned ID_W      = 8;
  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned STATUS_W  = 2;

  // action codes
  typedef enum logic [ACTION_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_RESERVE = 3'd1,
    OP_RELEASE = 3'd2,
    OP_CLOSE   = 3'd3,
    OP_LOOKUP  = 3'd4,
    OP_BIND    = 3'd5
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_WALK,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // item accepted this cycle
    logic exec;      // decode and apply the part done in the execute state
    logic scan;      // examine one bitmap word for alloc
    logic walk;      // advance the hint over used ids
    logic load_out;  // move the result into the output register
  } dia_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic need_walk;
    logic scan_done;
    logic walk_done;
    logic out_free;
  } dia_stat_t;

  // index of the lowest set bit of a bitmap word
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ hdl/descriptor_id_allocator.sv @@
// ----------------------------------------------------------------------------
// descriptor_id_allocator
// Next-fit bitmap allocator of numeric ids with an attached handle table.
//
// Usage:
//   Input channel (in_valid / in_stall) carries action, id and handle.
//   Output channel (out_valid / out_stall) returns status, result_id and
//   result_handle, exactly one result per item, in order.
//   One item is in work at a time; in_stall is low only while idle.
//   Each item passes the execute state, then for alloc the word scan and,
//   for reserve of the id at the hint, the word-wise hint walk, then the
//   finish state that loads the output register; the scan visits one
//   64-bit bitmap word per cycle, from the hint's word on, wrapping.
//   A new item is taken only after the last one has gone into the output
//   register, once the block is back in idle.
//   The result sits in an output register, so the next item is taken while
//   an earlier result is still stalled; a new result waits in the block
//   until that register is taken.
//   Reset (rst, synchronous) clears the bitmap, all handle valid bits and
//   the hint at once; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module descriptor_id_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dia_pkg::ACTION_W-1:0] action,
  input  logic [dia_pkg::ID_W-1:0]     id,
  input  logic [dia_pkg::HANDLE_W-1:0] handle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dia_pkg::STATUS_W-1:0] status,
  output logic [dia_pkg::ID_W-1:0]     result_id,
  output logic [dia_pkg::HANDLE_W-1:0] result_handle
);

  dia_pkg::dia_cmd_t  cmd;
  dia_pkg::dia_stat_t stat;

  // sequencer
  dia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // bitmap, handle table and result path
  dia_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .id            (id),
    .handle        (handle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .result_id     (result_id),
    .result_handle (result_handle)
  );

endmodule

@@ hdl/dia_ctrl.sv @@
// ----------------------------------------------------------------------------
// dia_ctrl
// Sequencer of the allocator: takes one item at a time, steps the datapath
// through execute, word scan or hint walk, and hands the result to the
// output register once it is free.
// ----------------------------------------------------------------------------
module dia_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dia_pkg::dia_stat_t stat,
  output dia_pkg::dia_cmd_t  cmd
);

  dia_pkg::state_t state;
  dia_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dia_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      dia_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) state_next = dia_pkg::S_EXEC;
      end
      dia_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_alloc) begin
          state_next = dia_pkg::S_SCAN;
        end else if (stat.need_walk) begin
          state_next = dia_pkg::S_WALK;
        end else begin
          state_next = dia_pkg::S_FINISH;
        end
      end
      dia_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_next = dia_pkg::S_FINISH;
      end
      dia_pkg::S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) state_next = dia_pkg::S_FINISH;
      end
      dia_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = dia_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dia_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/dia_dpath.sv @@
// ----------------------------------------------------------------------------
// dia_dpath
// Datapath of the allocator: use bitmap, handle memory with per-entry valid
// bits, search hint, the shared lowest-free-bit encoder, the result staging
// register and the output register.
// ----------------------------------------------------------------------------
module dia_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  dia_pkg::dia_cmd_t                   cmd,
  output dia_pkg::dia_stat_t                  stat,
  input  logic [dia_pkg::ACTION_W-1:0]        action,
  input  logic [dia_pkg::ID_W-1:0]            id,
  input  logic [dia_pkg::HANDLE_W-1:0]        handle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dia_pkg::STATUS_W-1:0]        status,
  output logic [dia_pkg::ID_W-1:0]            result_id,
  output logic [dia_pkg::HANDLE_W-1:0]        result_handle
);

  localparam int unsigned WB = dia_pkg::WORD_BITS;
  localparam int unsigned BW = dia_pkg::BIT_W;
  localparam int unsigned XW = dia_pkg::WIDX_W;
  localparam int unsigned HW = dia_pkg::HINT_W;

  // captured item
  logic [dia_pkg::ACTION_W-1:0] action_q;
  logic [dia_pkg::ID_W-1:0]     id_q;
  logic [dia_pkg::HANDLE_W-1:0] handle_q;

  // state
  logic [WB-1:0]                use_map [dia_pkg::NUM_WORDS];
  logic [dia_pkg::MAX_IDS-1:0]  hvalid;
  logic [dia_pkg::HANDLE_W-1:0] handle_mem [dia_pkg::MAX_IDS];
  logic [dia_pkg::HANDLE_W-1:0] mem_q;
  logic [HW-1:0]                hint;
  logic [XW-1:0]                scan_k;

  // staged result
  dia_pkg::status_t             res_status;
  logic [dia_pkg::ID_W-1:0]     res_id;
  logic [dia_pkg::HANDLE_W-1:0] res_handle;

  // decode helpers
  logic [XW-1:0]                id_w;
  logic [BW-1:0]                id_b;
  logic [XW-1:0]                hint_w;
  logic [BW-1:0]                hint_b;
  logic [XW-1:0]                scan_w;
  logic [XW-1:0]                rd_w;
  logic [WB-1:0]                rd_word;
  logic [WB-1:0]                enc_in;
  logic                         enc_hit;
  logic [BW-1:0]                enc_pos;
  logic [dia_pkg::HANDLE_W-1:0] hv;
  logic                         in_range;
  logic                         lower;
  dia_pkg::op_t                 op;

  assign op       = dia_pkg::op_t'(action_q);
  assign id_w     = id_q[BW +: XW];
  assign id_b     = id_q[BW-1:0];
  assign hint_w   = hint[BW +: XW];
  assign hint_b   = hint[BW-1:0];
  assign scan_w   = hint_w + scan_k;
  assign in_range = 32'(id_q) < dia_pkg::MAX_IDS;
  assign lower    = {1'b0, id_q} < hint;

  // attached handle of the captured id; an entry never bound reads as none
  assign hv = hvalid[id_q] ? mem_q : '0;

  // one bitmap word is examined per cycle, by the scan or by the hint walk
  assign rd_w    = cmd.scan ? scan_w : hint_w;
  assign rd_word = use_map[rd_w];
  assign enc_in  = cmd.scan ? ~rd_word : (~rd_word & ({WB{1'b1}} << hint_b));
  assign enc_hit = |enc_in;
  assign enc_pos = dia_pkg::lowest_set(enc_in);

  // status to the controller
  always_comb begin
    stat.is_alloc  = (op == dia_pkg::OP_ALLOC);
    stat.need_walk = (op == dia_pkg::OP_RESERVE) && in_range && ({1'b0, id_q} == hint);
    stat.scan_done = enc_hit || (scan_k == XW'(dia_pkg::NUM_WORDS - 1));
    stat.walk_done = hint[HW-1] || enc_hit;
    stat.out_free  = !out_valid || !out_stall;
  end

  // handle memory, registered read at accept
  always_ff @(posedge clk) begin
    if (cmd.exec && in_range && op == dia_pkg::OP_BIND) begin
      handle_mem[id_q] <= handle_q;
    end
    if (cmd.capture) begin
      mem_q <= handle_mem[id];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q <= action;
      id_q     <= id;
      handle_q <= handle;
    end
  end

  // bitmap, valid bits, hint and scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < dia_pkg::NUM_WORDS; w++) use_map[w] <= '0;
      hvalid <= '0;
      hint   <= '0;
      scan_k <= '0;
    end else begin
      if (cmd.exec && in_range) begin
        unique case (op)
          dia_pkg::OP_ALLOC: begin
            scan_k <= '0;
          end
          dia_pkg::OP_RESERVE: begin
            use_map[id_w][id_b] <= 1'b1;
          end
          dia_pkg::OP_RELEASE: begin
            if (hv == '0) begin
              use_map[id_w][id_b] <= 1'b0;
              if (lower) hint <= {1'b0, id_q};
            end
          end
          dia_pkg::OP_CLOSE: begin
            if (hv != '0) begin
              hvalid[id_q]        <= 1'b0;
              use_map[id_w][id_b] <= 1'b0;
              if (lower) hint <= {1'b0, id_q};
            end
          end
          dia_pkg::OP_BIND: begin
            hvalid[id_q] <= 1'b1;
          end
          default: begin
          end
        endcase
      end else if (cmd.exec) begin
        scan_k <= '0;
      end
      // alloc: one word per cycle starting at the hint's word, wrapping
      if (cmd.scan) begin
        scan_k <= scan_k + XW'(1);
        if (enc_hit) begin
          use_map[scan_w][enc_pos] <= 1'b1;
          hint <= HW'({scan_w, enc_pos}) + HW'(1);
        end
      end
      // hint walk over used ids, one word per cycle
      if (cmd.walk && !hint[HW-1]) begin
        if (enc_hit) begin
          hint <= HW'({hint_w, enc_pos});
        end else begin
          hint <= HW'({hint_w, BW'(0)}) + HW'(WB);
        end
      end
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_id <= id_q;
      if (op == dia_pkg::OP_ALLOC) begin
        res_status <= dia_pkg::ST_FULL;
      end else if ((action_q <= dia_pkg::OP_BIND) && !in_range) begin
        res_status <= dia_pkg::ST_RANGE;
      end else if (op == dia_pkg::OP_RELEASE && hv != '0) begin
        res_status <= dia_pkg::ST_REFUSED;
      end else if (op == dia_pkg::OP_CLOSE && hv == '0) begin
        res_status <= dia_pkg::ST_REFUSED;
      end else begin
        res_status <= dia_pkg::ST_OK;
      end
      if (op == dia_pkg::OP_LOOKUP && in_range) begin
        res_handle <= hv;
      end else begin
        res_handle <= '0;
      end
    end else if (cmd.scan && enc_hit) begin
      res_status <= dia_pkg::ST_OK;
      res_id     <= dia_pkg::ID_W'({scan_w, enc_pos});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status        <= res_status;
      result_id     <= res_id;
      result_handle <= res_handle;
    end
  end

endmodule

@@ hdl/dia_checker.sv @@
// ----------------------------------------------------------------------------
// dia_checker
// Port-level checks of the descriptor id allocator, attached by bind.
// ----------------------------------------------------------------------------
module dia_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [dia_pkg::STATUS_W-1:0] status,
  input logic [dia_pkg::ID_W-1:0]     result_id,
  input logic [dia_pkg::HANDLE_W-1:0] result_handle
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_id)
      && $stable(result_handle))
    else $error("stalled result changed");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while busy");

  // no result appears in the cycle right after an accept
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

  // every 8-bit id lies inside the pool
  a_no_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != dia_pkg::ST_RANGE)
    else $error("range status with full-width pool");

endmodule

bind descriptor_id_allocator dia_checker u_dia_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .result_id     (result_id),
  .result_handle (result_handle)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for descriptor_id_allocator. A behavioral copy of the
// id pool (use bitmap, handle table, search hint) predicts each result when
// its item is accepted. A monitor compares every result, field by field,
// with the oldest prediction. Stimulus runs directed cases, a fill to pool
// full and a drain, a long output hold-off and random traffic under several
// idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;

  // action codes the block treats as no-ops
  localparam logic [dia_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [dia_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  typedef struct packed {
    dia_pkg::status_t                status;
    logic [dia_pkg::ID_W-1:0]        rid;
    logic [dia_pkg::HANDLE_W-1:0]    rhandle;
  } alloc_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [dia_pkg::ACTION_W-1:0] action = '0;
  logic [dia_pkg::ID_W-1:0]     id = '0;
  logic [dia_pkg::HANDLE_W-1:0] handle = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [dia_pkg::STATUS_W-1:0] status;
  logic [dia_pkg::ID_W-1:0]     result_id;
  logic [dia_pkg::HANDLE_W-1:0] result_handle;

  // pool image kept by the predictor
  logic [dia_pkg::MAX_IDS-1:0]  id_used;
  logic [dia_pkg::HANDLE_W-1:0] id_handle [dia_pkg::MAX_IDS];
  logic [dia_pkg::HINT_W-1:0]   next_hint;

  alloc_result_t pending_results [$];
  int            errors = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   hold_cycles = 0;

  descriptor_id_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .id            (id),
    .handle        (handle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .result_id     (result_id),
    .result_handle (result_handle)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // pool state after reset
  initial begin
    id_used   = '0;
    next_hint = '0;
    foreach (id_handle[i]) id_handle[i] = '0;
  end

  // next-fit pool behavior, applied when an item is accepted
  function automatic alloc_result_t predict_pool(
      input logic [dia_pkg::ACTION_W-1:0] act,
      input logic [dia_pkg::ID_W-1:0] ident,
      input logic [dia_pkg::HANDLE_W-1:0] hnd);
    alloc_result_t res;
    int unsigned   first_word;
    int unsigned   w;
    int            granted;
    logic [dia_pkg::WORD_BITS-1:0] open_mask;
    res.status  = dia_pkg::ST_OK;
    res.rid     = ident;
    res.rhandle = '0;
    granted     = -1;
    // every 8-bit id lies inside the pool, so no range refusal can occur
    case (act)
      dia_pkg::OP_ALLOC: begin
        // hint word to the last word, then wrap from word 0
        first_word = next_hint / dia_pkg::WORD_BITS;
        for (int k = 0; k < dia_pkg::NUM_WORDS && granted < 0; k++) begin
          w = (first_word + k) % dia_pkg::NUM_WORDS;
          open_mask = ~id_used[w*dia_pkg::WORD_BITS +: dia_pkg::WORD_BITS];
          for (int b = 0; b < dia_pkg::WORD_BITS; b++) begin
            if (open_mask[b]) begin
              granted = w * dia_pkg::WORD_BITS + b;
              break;
            end
          end
        end
        if (granted < 0) begin
          res.status = dia_pkg::ST_FULL;
        end else begin
          id_used[granted] = 1'b1;
          next_hint        = dia_pkg::HINT_W'(granted + 1);
          res.rid          = dia_pkg::ID_W'(granted);
        end
      end
      dia_pkg::OP_RESERVE: begin
        id_used[ident] = 1'b1;
        // walk the hint over used ids
        if (ident == next_hint) begin
          while (next_hint < dia_pkg::MAX_IDS && id_used[next_hint[dia_pkg::ID_W-1:0]])
            next_hint++;
        end
      end
      dia_pkg::OP_RELEASE: begin
        if (id_handle[ident] != 0) begin
          res.status = dia_pkg::ST_REFUSED;
        end else begin
          id_used[ident] = 1'b0;
          if (ident < next_hint) next_hint = dia_pkg::HINT_W'(ident);
        end
      end
      dia_pkg::OP_CLOSE: begin
        if (id_handle[ident] == 0) begin
          res.status = dia_pkg::ST_REFUSED;
        end else begin
          id_handle[ident] = '0;
          id_used[ident]   = 1'b0;
          if (ident < next_hint) next_hint = dia_pkg::HINT_W'(ident);
        end
      end
      dia_pkg::OP_LOOKUP: begin
        res.rhandle = id_handle[ident];
      end
      dia_pkg::OP_BIND: begin
        id_handle[ident] = hnd;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // offer one item, starting at a falling edge; returns at a falling edge
  task automatic send_item(input logic [dia_pkg::ACTION_W-1:0] act,
                           input logic [dia_pkg::ID_W-1:0] ident,
                           input logic [dia_pkg::HANDLE_W-1:0] hnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action   = act;
    id       = ident;
    handle   = hnd;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_results.push_back(predict_pool(act, ident, hnd));
    @(negedge clk);
  endtask

  // receiver: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d id %0d handle %h", $time, status,
                 result_id, result_handle);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (result_id !== want.rid) begin
          $display("%0t: result_id expected %0d actual %0d", $time, want.rid, result_id);
          errors++;
        end
        if (result_handle !== want.rhandle) begin
          $display("%0t: result_handle expected %h actual %h", $time, want.rhandle,
                   result_handle);
          errors++;
        end
      end
    end
  end

  function automatic logic [dia_pkg::HANDLE_W-1:0] pick_handle();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // random id, biased toward used or bound ids when asked
  function automatic logic [dia_pkg::ID_W-1:0] pick_id(input bit want_used,
                                                       input bit want_bound);
    logic [dia_pkg::ID_W-1:0] cand;
    cand = dia_pkg::ID_W'($urandom_range(dia_pkg::MAX_IDS - 1));
    for (int t = 0; t < 16; t++) begin
      if ((!want_used || id_used[cand]) && (!want_bound || id_handle[cand] != 0)) return cand;
      cand = dia_pkg::ID_W'($urandom_range(dia_pkg::MAX_IDS - 1));
    end
    return cand;
  endfunction

  // reserve target: often the id at the hint to trigger the hint walk
  function automatic logic [dia_pkg::ID_W-1:0] pick_reserve_id();
    if (next_hint < dia_pkg::MAX_IDS && $urandom_range(1))
      return next_hint[dia_pkg::ID_W-1:0];
    return dia_pkg::ID_W'($urandom_range(dia_pkg::MAX_IDS - 1));
  endfunction

  task automatic send_random_item(input bit filling);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < (filling ? 45 : 15))
      send_item(dia_pkg::OP_ALLOC, dia_pkg::ID_W'($urandom()), pick_handle());
    else if (roll < (filling ? 60 : 22))
      send_item(dia_pkg::OP_RESERVE, pick_reserve_id(), pick_handle());
    else if (roll < (filling ? 66 : 50))
      send_item(dia_pkg::OP_RELEASE, pick_id(1'b1, 1'b0), pick_handle());
    else if (roll < (filling ? 70 : 65))
      send_item(dia_pkg::OP_CLOSE, pick_id(1'b1, 1'b1), pick_handle());
    else if (roll < (filling ? 80 : 75))
      send_item(dia_pkg::OP_LOOKUP, pick_id(1'b1, 1'b0), pick_handle());
    else if (roll < 97)
      send_item(dia_pkg::OP_BIND, pick_id(1'b1, 1'b0), pick_handle());
    else
      send_item($urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B, dia_pkg::ID_W'($urandom()),
                pick_handle());
  endtask

  // every action, attachment refusals, bound free id, spare codes
  task automatic test_directed_ops();
    send_item(dia_pkg::OP_ALLOC,   8'd0,   32'h0000_0000);
    send_item(dia_pkg::OP_ALLOC,   8'd255, 32'hFFFF_FFFF);
    send_item(dia_pkg::OP_RESERVE, 8'd2,   32'h0000_0000);
    send_item(dia_pkg::OP_RESERVE, 8'd200, 32'h0000_0000);
    send_item(dia_pkg::OP_RESERVE, 8'd200, 32'h0000_0000);
    send_item(dia_pkg::OP_BIND,    8'd1,   32'hFFFF_FFFF);
    send_item(dia_pkg::OP_LOOKUP,  8'd1,   32'h0000_0000);
    send_item(dia_pkg::OP_RELEASE, 8'd1,   32'h0000_0000);
    send_item(dia_pkg::OP_CLOSE,   8'd1,   32'h0000_0000);
    send_item(dia_pkg::OP_CLOSE,   8'd1,   32'h0000_0000);
    send_item(dia_pkg::OP_RELEASE, 8'd0,   32'h0000_0000);
    send_item(dia_pkg::OP_BIND,    8'd255, 32'h8000_0001);
    send_item(dia_pkg::OP_LOOKUP,  8'd255, 32'h0000_0000);
    send_item(dia_pkg::OP_RELEASE, 8'd255, 32'h0000_0000);
    send_item(dia_pkg::OP_BIND,    8'd1,   32'h5A5A_A5A5);
    send_item(dia_pkg::OP_ALLOC,   8'd0,   32'h0000_0000);
    send_item(dia_pkg::OP_ALLOC,   8'd0,   32'h0000_0000);
    send_item(dia_pkg::OP_CLOSE,   8'd1,   32'h0000_0000);
    send_item(dia_pkg::OP_LOOKUP,  8'd0,   32'h0000_0000);
    send_item(ACT_SPARE_A,         8'hAA,  32'hFFFF_FFFF);
    send_item(ACT_SPARE_B,         8'h55,  32'h0000_0000);
    send_item(dia_pkg::OP_BIND,    8'd255, 32'h0000_0000);
    send_item(dia_pkg::OP_RELEASE, 8'd255, 32'h0000_0000);
  endtask

  // fill the pool to exhaustion, probe the full case, then drain part of it
  task automatic test_pool_full();
    send_idle_pct = 0;
    stall_pct     = 0;
    while ($countones(id_used) < dia_pkg::MAX_IDS) begin
      if ($urandom_range(99) < 75)
        send_item(dia_pkg::OP_ALLOC, dia_pkg::ID_W'($urandom()), pick_handle());
      else send_item(dia_pkg::OP_RESERVE, pick_reserve_id(), pick_handle());
    end
    repeat (3) send_item(dia_pkg::OP_ALLOC, dia_pkg::ID_W'($urandom()), pick_handle());
    send_item(dia_pkg::OP_RESERVE, dia_pkg::ID_W'($urandom()), pick_handle());
    repeat (40) begin
      logic [dia_pkg::ID_W-1:0] victim;
      victim = pick_id(1'b1, 1'b0);
      if (id_handle[victim] != 0) send_item(dia_pkg::OP_CLOSE, victim, pick_handle());
      else send_item(dia_pkg::OP_RELEASE, victim, pick_handle());
    end
  endtask

  // output held off for a long stretch while items keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    hold_cycles = 150;
    @(negedge clk);
    repeat (12) send_random_item(1'b0);
  endtask

  // mixed traffic, alternating fill and drain bias
  task automatic test_random_traffic(input int unsigned n, input int unsigned idle_pct,
                                     input int unsigned hold_pct);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    for (int unsigned i = 0; i < n; i++) send_random_item(((i / 45) % 2) == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_ops();
    test_pool_full();
    test_backpressure();
    test_random_traffic(60, 0, 0);
    test_random_traffic(60, 73, 0);
    test_random_traffic(60, 0, 73);
    test_random_traffic(60, 18, 18);
    // drain and let the last result settle
    in_valid      = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0) begin
      $display("descriptor_id_allocator regression: pass");
    end else begin
      $display("descriptor_id_allocator regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6ms;
    $display("descriptor_id_allocator regression: fail");
    $finish;
  end

endmodule

@@ descriptor_id_allocator.f @@
hdl/dia_pkg.sv
hdl/dia_ctrl.sv
hdl/dia_dpath.sv
hdl/descriptor_id_allocator.sv
hdl/dia_checker.sv
tb/testbench.sv
